/* hdl/swbh_pkg.sv */
// Shared constants, item type and register indices for the sliding-window bin histogram.
// No dependencies.
package swbh_pkg;

    localparam int WINDOW_MAX   = 256;
    localparam int NUM_BINS     = 4;
    localparam int SAMPLE_BITS  = 8;

    localparam int PTR_W        = $clog2(WINDOW_MAX);
    localparam int FILL_W       = PTR_W + 1;
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int COUNT_W      = 9;
    localparam int WIN_CFG_W    = 9;
    localparam int DIV_W        = 8;
    localparam int CMP_W        = SAMPLE_BITS + DIV_W;
    localparam int RESULT_SLOTS = 4;
    localparam int CFG_IDX_W    = 2;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FILL_W-1:0]    WINDOW_MAX_F  = FILL_W'(WINDOW_MAX);
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
    localparam logic [WIN_CFG_W-1:0] WINDOW_RESET  = WIN_CFG_W'(20);
    localparam logic [DIV_W-1:0]     DIVISOR_RESET = DIV_W'(10);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_DIVISOR = CFG_IDX_W'(1);

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             start;
        logic             last;
    } item_t;

endpackage

/* hdl/swbh_front.sv */
// Front end: sample transfer, bin classification, push into the item queue.
// Depends on swbh_pkg.
module swbh_front
    import swbh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   start_of_series,
    input  logic                   last_in_series,
    input  logic [DIV_W-1:0]       bin_divisor,
    output logic                   push,
    output item_t                  push_item,
    input  logic                   full
);

    logic             front_valid_reg;
    item_t            front_item_reg;
    logic [BIN_W-1:0] bin_next;

    // bin = sample / divisor clamped, by compares to multiples; top bin for sample 0
    always_comb
    begin
        logic [CMP_W-1:0] thresh;
        thresh   = '0;
        bin_next = '0;
        if (sample == '0)
        begin
            bin_next = BIN_W'(NUM_BINS - 1);
        end
        else if (bin_divisor == '0)
        begin
            bin_next = BIN_W'(NUM_BINS - 2);
        end
        else
        begin
            for (int k = 1; k <= NUM_BINS - 2; k++)
            begin
                thresh = CMP_W'(bin_divisor) * CMP_W'(k);
                if (CMP_W'(sample) >= thresh)
                begin
                    bin_next = BIN_W'(k);
                end
            end
        end
    end

    assign sample_stall = front_valid_reg && full;
    assign push         = front_valid_reg && !full;
    assign push_item    = front_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (!sample_stall)
        begin
            front_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
        begin
            front_item_reg.bin   <= bin_next;
            front_item_reg.start <= start_of_series;
            front_item_reg.last  <= last_in_series;
        end
    end

endmodule

/* hdl/swbh_queue.sv */
// Short item queue between front and back ends.
// Depends on swbh_pkg.
module swbh_queue
    import swbh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output item_t q_item
);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue push lost");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

/* hdl/swbh_back.sv */
// Back end: delay line memory, window bookkeeping, bin counters and result register.
// Depends on swbh_pkg.
module swbh_back
    import swbh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FILL_W-1:0]  window_eff,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [COUNT_W-1:0] count_bin0,
    output logic [COUNT_W-1:0] count_bin1,
    output logic [COUNT_W-1:0] count_bin2,
    output logic [COUNT_W-1:0] count_zero_bin,
    output logic               series_end
);

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             start;
        logic             last;
        logic             drop;
        logic             emit;
        logic [PTR_W-1:0] wr_addr;
        logic             byp;
        logic [BIN_W-1:0] byp_bin;
    } stage_t;

    logic [BIN_W-1:0]   delay_mem [WINDOW_MAX];

    logic               a_valid_reg;
    item_t              a_item_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [PTR_W-1:0]   wp_reg;

    logic               b_valid_reg;
    stage_t             b_reg;
    logic [BIN_W-1:0]   rd_data_reg;
    logic [COUNT_W-1:0] counts_reg [NUM_BINS];

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg [RESULT_SLOTS];
    logic               out_end_reg;

    logic               a_fire;
    logic               b_fire;
    logic [FILL_W-1:0]  fill_eff;
    logic [FILL_W-1:0]  fill_inc;
    logic [PTR_W-1:0]   wp_eff;
    logic [FILL_W-1:0]  rd_diff;
    logic [PTR_W-1:0]   rd_idx;
    logic               a_drop;
    logic               a_emit;
    logic               a_byp;
    logic [BIN_W-1:0]   old_bin;
    logic [COUNT_W-1:0] counts_next [NUM_BINS];
    logic [COUNT_W-1:0] slot_next [RESULT_SLOTS];

    // stage A: window bookkeeping and delay line read
    assign fill_eff = a_item_reg.start ? '0 : fill_reg;
    assign wp_eff   = a_item_reg.start ? '0 : wp_reg;
    assign a_drop   = (fill_eff >= window_eff);
    assign rd_diff  = {1'b0, wp_eff} - window_eff;
    assign rd_idx   = rd_diff[PTR_W-1:0];
    assign fill_inc = (fill_eff < WINDOW_MAX_F) ? fill_eff + 1'b1 : fill_eff;
    assign a_emit   = (fill_inc >= window_eff);
    // read in the same cycle as the write of the item ahead returns stale data
    assign a_byp    = b_fire && (rd_idx == b_reg.wr_addr);

    assign b_fire = b_valid_reg && (!b_reg.emit || !out_valid_reg || !result_stall);
    assign a_fire = a_valid_reg && (!b_valid_reg || b_fire);
    assign pop    = q_valid && (!a_valid_reg || a_fire);

    // stage B: counter update
    assign old_bin = b_reg.byp ? b_reg.byp_bin : rd_data_reg;

    always_comb
    begin
        logic [COUNT_W-1:0] base;
        logic [COUNT_W-1:0] mid;
        base = '0;
        mid  = '0;
        for (int k = 0; k < NUM_BINS; k++)
        begin
            base = b_reg.start ? '0 : counts_reg[k];
            mid  = base;
            if (b_reg.drop && (old_bin == BIN_W'(k)) && (base != '0))
            begin
                mid = base - 1'b1;
            end
            counts_next[k] = mid;
            if ((b_reg.bin == BIN_W'(k)) && (mid != COUNT_MAX))
            begin
                counts_next[k] = mid + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < RESULT_SLOTS - 1; j++)
        begin
            slot_next[j] = (j < NUM_BINS - 1) ? counts_next[j] : '0;
        end
        slot_next[RESULT_SLOTS-1] = counts_next[NUM_BINS-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_fire)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_fire)
            begin
                b_valid_reg <= 1'b1;
                fill_reg    <= fill_inc;
                wp_reg      <= wp_eff + 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire)
            begin
                for (int k = 0; k < NUM_BINS; k++)
                begin
                    counts_reg[k] <= counts_next[k];
                end
            end

            if (b_fire && b_reg.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_item_reg <= q_item;
        end
        if (a_fire)
        begin
            b_reg.bin     <= a_item_reg.bin;
            b_reg.start   <= a_item_reg.start;
            b_reg.last    <= a_item_reg.last;
            b_reg.drop    <= a_drop;
            b_reg.emit    <= a_emit;
            b_reg.wr_addr <= wp_eff;
            b_reg.byp     <= a_byp;
            b_reg.byp_bin <= b_reg.bin;
        end
        if (b_fire && b_reg.emit)
        begin
            for (int j = 0; j < RESULT_SLOTS; j++)
            begin
                out_count_reg[j] <= slot_next[j];
            end
            out_end_reg <= b_reg.last;
        end
    end

    // delay line
    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            rd_data_reg <= delay_mem[rd_idx];
        end
        if (b_fire)
        begin
            delay_mem[b_reg.wr_addr] <= b_reg.bin;
        end
    end

    assign result_valid   = out_valid_reg;
    assign count_bin0     = out_count_reg[0];
    assign count_bin1     = out_count_reg[1];
    assign count_bin2     = out_count_reg[2];
    assign count_zero_bin = out_count_reg[RESULT_SLOTS-1];
    assign series_end     = out_end_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= WINDOW_MAX_F)
        else $error("fill level beyond window maximum");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_reg.emit) |=> result_valid)
        else $error("result lost at output register");

    a_bypass_unit_window: assert property (@(posedge clk) disable iff (!rst_n)
        (a_fire && a_drop && a_byp) |-> (window_eff == FILL_W'(1)))
        else $error("delay line bypass with window above one");

endmodule

/* hdl/sliding_window_bin_histogram_top.sv */
// Throughput: one sample per cycle unless result_stall holds back a result; front register,
// queue, stage A and stage B each pass one item per cycle, the delay line memory is read in
// stage A and written in stage B.
// Reset: asynchronous, clears control state, counters, fill level and write pointer;
// the window length returns to 20 and bin_divisor to 10; the delay line is not cleared.
// Holds the configuration registers; depends on swbh_pkg, swbh_front, swbh_queue, swbh_back.
module sliding_window_bin_histogram_top
    import swbh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [WIN_CFG_W-1:0]   cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   start_of_series,
    input  logic                   last_in_series,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [COUNT_W-1:0]     count_bin0,
    output logic [COUNT_W-1:0]     count_bin1,
    output logic [COUNT_W-1:0]     count_bin2,
    output logic [COUNT_W-1:0]     count_zero_bin,
    output logic                   series_end
);

    logic [WIN_CFG_W-1:0] win_len_reg;
    logic [DIV_W-1:0]     bin_divisor_reg;
    logic [FILL_W-1:0]    window_eff;
    logic                 push;
    item_t                push_item;
    logic                 full;
    logic                 pop;
    logic                 q_valid;
    item_t                q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg     <= WINDOW_RESET;
            bin_divisor_reg <= DIVISOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE: win_len_reg <= cfg_data;
                REG_BIN_DIVISOR: bin_divisor_reg <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize clamps to the delay line depth
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            window_eff = FILL_W'(1);
        end
        else if (int'(win_len_reg) > WINDOW_MAX)
        begin
            window_eff = WINDOW_MAX_F;
        end
        else
        begin
            window_eff = FILL_W'(win_len_reg);
        end
    end

    swbh_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .start_of_series (start_of_series),
        .last_in_series  (last_in_series),
        .bin_divisor     (bin_divisor_reg),
        .push            (push),
        .push_item       (push_item),
        .full            (full)
    );

    swbh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    swbh_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_eff     (window_eff),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .count_bin0     (count_bin0),
        .count_bin1     (count_bin1),
        .count_bin2     (count_bin2),
        .count_zero_bin (count_zero_bin),
        .series_end     (series_end)
    );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for sliding_window_bin_histogram_top: directed and random series
// checked against an in-bench histogram predictor. Depends on swbh_pkg and the block's RTL.
module tb_top;
    import swbh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
    localparam int SAMPLE_MAX   = 2 ** SAMPLE_BITS - 1;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET  = 1050;
    localparam int LARGE_PHASE  = 3;

    typedef struct packed {
        logic [COUNT_W-1:0] bin0;
        logic [COUNT_W-1:0] bin1;
        logic [COUNT_W-1:0] bin2;
        logic [COUNT_W-1:0] zero_bin;
        logic               last;
    } histogram_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WIN_CFG_W-1:0]   cfg_data;
    logic                   sample_valid;
    logic                   sample_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   start_of_series;
    logic                   last_in_series;
    logic                   result_valid;
    logic                   result_stall;
    logic [COUNT_W-1:0]     count_bin0;
    logic [COUNT_W-1:0]     count_bin1;
    logic [COUNT_W-1:0]     count_bin2;
    logic [COUNT_W-1:0]     count_zero_bin;
    logic                   series_end;

    // predictor state
    logic [WIN_CFG_W-1:0]   window_cfg  = WINDOW_RESET;
    logic [DIV_W-1:0]       divisor_cfg = DIVISOR_RESET;
    logic [BIN_W-1:0]       bin_history [WINDOW_MAX];
    logic [COUNT_W-1:0]     bin_tally [NUM_BINS];
    int                     fill_count = 0;
    logic [PTR_W-1:0]       history_ptr = '0;
    histogram_t             histograms_due [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fault_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;

    sliding_window_bin_histogram_top i_dut (.*);

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic int window_eff();
        if (window_cfg == 0)
            return 1;
        if (window_cfg > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(window_cfg);
    endfunction

    function automatic logic [BIN_W-1:0] bin_for(input logic [SAMPLE_BITS-1:0] s);
        int q;
        if (s == 0)
            return BIN_W'(NUM_BINS - 1);
        if (divisor_cfg == 0)
            return BIN_W'(NUM_BINS - 2);
        q = int'(s) / int'(divisor_cfg);
        return BIN_W'((q > NUM_BINS - 2) ? NUM_BINS - 2 : q);
    endfunction

    task automatic update_histogram(input logic [SAMPLE_BITS-1:0] s, input logic sos,
                                    input logic last);
        int               w;
        int               idx;
        logic [BIN_W-1:0] b;
        histogram_t       h;
        w = window_eff();
        if (sos)
        begin
            foreach (bin_history[i])
                bin_history[i] = '0;
            foreach (bin_tally[i])
                bin_tally[i] = '0;
            fill_count  = 0;
            history_ptr = '0;
        end
        b = bin_for(s);
        if (fill_count >= w)
        begin
            idx = (int'(history_ptr) + WINDOW_MAX - w) % WINDOW_MAX;
            if (bin_tally[bin_history[idx]] != 0)
                bin_tally[bin_history[idx]]--;
        end
        bin_history[history_ptr] = b;
        history_ptr = PTR_W'((int'(history_ptr) + 1) % WINDOW_MAX);
        if (bin_tally[b] != COUNT_MAX)
            bin_tally[b]++;
        if (fill_count < WINDOW_MAX)
            fill_count++;
        if (fill_count >= w)
        begin
            h.bin0     = (0 < NUM_BINS - 1) ? bin_tally[0] : '0;
            h.bin1     = (1 < NUM_BINS - 1) ? bin_tally[1] : '0;
            h.bin2     = (2 < NUM_BINS - 1) ? bin_tally[2] : '0;
            h.zero_bin = bin_tally[NUM_BINS - 1];
            h.last     = last;
            histograms_due = {histograms_due, h};
        end
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_v,
                               input logic [COUNT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fault_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        histogram_t h;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_WINDOW_SIZE)
                    window_cfg = cfg_data;
                else if (cfg_index == REG_BIN_DIVISOR)
                    divisor_cfg = cfg_data[DIV_W-1:0];
            end
            if (sample_valid && !sample_stall)
                update_histogram(sample, start_of_series, last_in_series);
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (histograms_due.size() == 0)
                begin
                    $display("%0t: unexpected histogram, expected none, got %0d/%0d/%0d/%0d end %0b",
                             $time, count_bin0, count_bin1, count_bin2, count_zero_bin,
                             series_end);
                    fault_count++;
                end
                else
                begin
                    h = histograms_due.pop_front();
                    check_field("count_bin0", h.bin0, count_bin0);
                    check_field("count_bin1", h.bin1, count_bin1);
                    check_field("count_bin2", h.bin2, count_bin2);
                    check_field("count_zero_bin", h.zero_bin, count_zero_bin);
                    check_field("series_end", COUNT_W'(h.last), COUNT_W'(series_end));
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic sos,
                               input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid    <= 1'b1;
        sample          <= s;
        start_of_series <= sos;
        last_in_series  <= last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // sender holds off until every histogram is out and the pipeline has emptied
    task automatic wait_for_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (histograms_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
        endcase
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        int t;
        case ($urandom_range(7))
            0: t = 0;
            1: t = SAMPLE_MAX;
            2, 3: t = int'(divisor_cfg) * int'($urandom_range(1, NUM_BINS - 2))
                      - int'($urandom_range(1));
            default: t = int'($urandom_range(SAMPLE_MAX));
        endcase
        if (t < 0)
            t = 0;
        if (t > SAMPLE_MAX)
            t = SAMPLE_MAX;
        return SAMPLE_BITS'(t);
    endfunction

    function automatic logic [WIN_CFG_W-1:0] pick_window(input int phase);
        if (phase == LARGE_PHASE)
            return '1;
        if (phase % 5 == 0)
            return '0;
        if ($urandom_range(3) == 0)
            return WIN_CFG_W'($urandom_range(1, 4));
        return WIN_CFG_W'($urandom_range(5, 40));
    endfunction

    function automatic logic [WIN_CFG_W-1:0] pick_divisor();
        logic [DIV_W-1:0] d;
        case ($urandom_range(5))
            0: d = '0;
            1: d = DIV_W'(1);
            2: d = '1;
            default: d = DIV_W'($urandom_range(2, 127));
        endcase
        return {1'($urandom_range(1)), d};
    endfunction

    task automatic send_series(input bit fresh);
        int w;
        int len;
        w   = window_eff();
        len = w + int'($urandom_range(w > 64 ? 20 : 30));
        for (int i = 0; i < len; i++)
            send_sample(rand_sample(), (i == 0 && fresh) || ($urandom_range(49) == 0),
                        (i == len - 1) || ($urandom_range(15) == 0));
    endtask

    // reset window and divisor; an early series end is swallowed before the window fills
    task automatic test_reset_defaults();
        logic [SAMPLE_BITS-1:0] sweep [0:20];
        sweep = '{8'd0, 8'd255, 8'd9, 8'd10, 8'd11, 8'd19, 8'd20, 8'd21, 8'd29, 8'd30,
                  8'd31, 8'd1, 8'd2, 8'd100, 8'd200, 8'd0, 8'd0, 8'd128, 8'd254, 8'd40,
                  8'd50};
        for (int i = 0; i <= 20; i++)
            send_sample(sweep[i], i == 0, i == 4 || i == 20);
        wait_for_results();
    endtask

    // window of zero acts as one, divisor of zero sends every nonzero sample to bin 2
    task automatic test_degenerate_config();
        write_reg(REG_WINDOW_SIZE, '0);
        write_reg(REG_BIN_DIVISOR, WIN_CFG_W'(9'h100));
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, WIN_CFG_W'(9'h0AA));
        send_sample(8'd0, 1'b1, 1'b0);
        send_sample(8'd1, 1'b0, 1'b0);
        send_sample(8'd255, 1'b0, 1'b0);
        send_sample(8'd128, 1'b0, 1'b1);
        wait_for_results();
        write_reg(REG_WINDOW_SIZE, WIN_CFG_W'(2));
        write_reg(REG_BIN_DIVISOR, WIN_CFG_W'(1));
        send_sample(8'd1, 1'b1, 1'b0);
        send_sample(8'd2, 1'b0, 1'b0);
        send_sample(8'd0, 1'b0, 1'b0);
        send_sample(8'd255, 1'b0, 1'b1);
        wait_for_results();
    endtask

    // random series per phase; some phases carry on the previous series across a reconfigure
    task automatic test_random_series();
        int phase;
        int n_series;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            set_idling(phase % 4);
            wait_for_results();
            write_reg(REG_WINDOW_SIZE, pick_window(phase));
            write_reg(REG_BIN_DIVISOR, pick_divisor());
            n_series = (phase == LARGE_PHASE) ? 1 : int'($urandom_range(1, 3));
            for (int k = 0; k < n_series; k++)
                send_series(k != 0 || phase == LARGE_PHASE || $urandom_range(3) != 0);
            phase++;
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        sample_valid    <= 1'b0;
        sample          <= '0;
        start_of_series <= 1'b0;
        last_in_series  <= 1'b0;
        result_stall    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_degenerate_config();
        test_random_series();

        $display("tb: %0d samples, %0d histograms checked, %0d register writes", items_sent,
                 results_seen, reg_writes);
        $display("tb: windows from 0 to 511, divisors 0 to 255, with and without back-pressure");
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("tb: failure");
        $finish;
    end

endmodule
